// ===== rtl/core/fadd_pkg.sv =====
package fadd_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_W         = OPERAND_WIDTH - 1;
    localparam int SUM_W         = 2 * OPERAND_WIDTH;
    localparam int LCM_W         = 2 * DEN_W;
    localparam int SHIFT_W       = $clog2(DEN_W);
    localparam int CNT_W         = $clog2(DEN_W + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef enum logic [2:0] {
        MUL_LCM    = 3'b001,
        MUL_FIRST  = 3'b010,
        MUL_SECOND = 3'b100
    } t_mul_step;

endpackage

// ===== rtl/core/fraction_adder_common_denominator.sv =====
// Adds two fractions a/b + c/d over their least common denominator L = lcm(b, d) and returns
// a*(L/b) + c*(L/d) over L, unreduced. One transaction at a time: the input is stalled from
// acceptance until the result is loaded into the output register, which then waits for the
// receiver while the next transaction may already be accepted. After acceptance, a transaction
// runs binary gcd steps (one shift or subtract each, at most 2*(OPERAND_WIDTH-2) steps) until
// a step finds the two values equal, then two restoring divisions (one quotient bit per cycle,
// d/g then b/g), then three products on one shared multiplier (lcm, first term, second term),
// and then hands over the result. The next transaction is accepted in the cycle after the
// hand-over at the earliest, and a result still stalled in the output register delays the
// hand-over. A zero denominator skips all of this and goes straight to the hand-over of the
// error result.
module fraction_adder_common_denominator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [fadd_pkg::OPERAND_WIDTH-1:0] i_first_numerator,
    input  logic        [fadd_pkg::DEN_W-1:0]     i_first_denominator,
    input  logic signed [fadd_pkg::OPERAND_WIDTH-1:0] i_second_numerator,
    input  logic        [fadd_pkg::DEN_W-1:0]     i_second_denominator,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [fadd_pkg::SUM_W-1:0]     o_sum_numerator,
    output logic        [fadd_pkg::LCM_W-1:0]     o_sum_denominator,
    output logic                                  o_zero_denominator_error
);
    import fadd_pkg::*;

    t_state    r_state, n_state;
    t_mul_step r_mul_step, n_mul_step;

    logic signed [OPERAND_WIDTH-1:0] r_a, n_a, r_c, n_c;
    logic [DEN_W-1:0]   r_b, n_b, r_d, n_d;
    logic [DEN_W-1:0]   r_x, n_x, r_y, n_y, r_g, n_g;
    logic [SHIFT_W-1:0] r_k, n_k;
    logic [DEN_W-1:0]   r_rem, n_rem, r_quo, n_quo, r_qd, n_qd, r_qb, n_qb;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_div_sel, n_div_sel;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic [LCM_W-1:0]   r_lcm, n_lcm;
    logic               r_err, n_err;

    logic               r_out_valid, n_out_valid;
    logic signed [SUM_W-1:0] r_out_num, n_out_num;
    logic [LCM_W-1:0]   r_out_den, n_out_den;
    logic               r_out_err, n_out_err;

    // divider step
    logic [DEN_W:0]     w_shifted;
    logic               w_ge;
    logic [DEN_W:0]     w_diff;
    logic [DEN_W-1:0]   w_quo_next;

    // shared multiplier
    logic signed [OPERAND_WIDTH-1:0] w_mul_x, w_mul_y;
    logic signed [SUM_W-1:0]         w_prod;

    assign w_shifted  = {r_rem, r_quo[DEN_W-1]};
    assign w_ge       = (w_shifted >= {1'b0, r_g});
    assign w_diff     = w_shifted - {1'b0, r_g};
    assign w_quo_next = {r_quo[DEN_W-2:0], w_ge};

    always_comb begin
        case (r_mul_step)
            MUL_LCM: begin
                w_mul_x = $signed({1'b0, r_b});
                w_mul_y = $signed({1'b0, r_qd});
            end
            MUL_FIRST: begin
                w_mul_x = r_a;
                w_mul_y = $signed({1'b0, r_qd});
            end
            default: begin
                w_mul_x = r_c;
                w_mul_y = $signed({1'b0, r_qb});
            end
        endcase
    end

    assign w_prod = w_mul_x * w_mul_y;

    always_comb begin
        n_state     = r_state;
        n_mul_step  = r_mul_step;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_x         = r_x;
        n_y         = r_y;
        n_g         = r_g;
        n_k         = r_k;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_qd        = r_qd;
        n_qb        = r_qb;
        n_cnt       = r_cnt;
        n_div_sel   = r_div_sel;
        n_acc       = r_acc;
        n_lcm       = r_lcm;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_out_num   = r_out_num;
        n_out_den   = r_out_den;
        n_out_err   = r_out_err;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a = i_first_numerator;
                    n_b = i_first_denominator;
                    n_c = i_second_numerator;
                    n_d = i_second_denominator;
                    if (i_first_denominator == '0 || i_second_denominator == '0) begin
                        n_acc   = '0;
                        n_lcm   = '0;
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_x     = i_first_denominator;
                        n_y     = i_second_denominator;
                        n_k     = '0;
                        n_err   = 1'b0;
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                // binary gcd: strip common twos, then shift or subtract odd values
                if (r_x == r_y) begin
                    n_g       = r_x << r_k;
                    n_quo     = r_d;
                    n_rem     = '0;
                    n_cnt     = '0;
                    n_div_sel = 1'b0;
                    n_state   = S_DIV;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x > r_y) begin
                    n_x = (r_x - r_y) >> 1;
                end else begin
                    n_y = (r_y - r_x) >> 1;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_diff[DEN_W-1:0] : w_shifted[DEN_W-1:0];
                n_quo = w_quo_next;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DEN_W - 1)) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (!r_div_sel) begin
                        n_qd      = w_quo_next;
                        n_quo     = r_b;
                        n_div_sel = 1'b1;
                    end else begin
                        n_qb       = w_quo_next;
                        n_mul_step = MUL_LCM;
                        n_state    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                case (r_mul_step)
                    MUL_LCM: begin
                        n_lcm      = w_prod[LCM_W-1:0];
                        n_mul_step = MUL_FIRST;
                    end
                    MUL_FIRST: begin
                        n_acc      = w_prod;
                        n_mul_step = MUL_SECOND;
                    end
                    default: begin
                        n_acc   = r_acc + w_prod;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_acc;
                    n_out_den   = r_lcm;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_step <= n_mul_step;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_d        <= n_d;
        r_x        <= n_x;
        r_y        <= n_y;
        r_g        <= n_g;
        r_k        <= n_k;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_qd       <= n_qd;
        r_qb       <= n_qb;
        r_cnt      <= n_cnt;
        r_div_sel  <= n_div_sel;
        r_acc      <= n_acc;
        r_lcm      <= n_lcm;
        r_err      <= n_err;
        r_out_num  <= n_out_num;
        r_out_den  <= n_out_den;
        r_out_err  <= n_out_err;
    end

    assign o_in_stall               = (r_state != S_IDLE);
    assign o_out_valid              = r_out_valid;
    assign o_sum_numerator          = r_out_num;
    assign o_sum_denominator        = r_out_den;
    assign o_zero_denominator_error = r_out_err;

endmodule

// ===== rtl/core/fadd_checker.sv =====
module fadd_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_stall,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [fadd_pkg::SUM_W-1:0]     o_sum_numerator,
    input  logic        [fadd_pkg::LCM_W-1:0]     o_sum_denominator,
    input  logic                                  o_zero_denominator_error
);
    import fadd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_sum_numerator)
            && $stable(o_sum_denominator) && $stable(o_zero_denominator_error))
        else $error("stalled result changed");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_denominator_error |->
            o_sum_numerator == '0 && o_sum_denominator == '0)
        else $error("error result carries nonzero fields");

    a_lcm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_zero_denominator_error |-> o_sum_denominator != '0)
        else $error("zero common denominator without error");

endmodule

bind fraction_adder_common_denominator fadd_checker u_fadd_checker (.*);
